// ----- rtl/sdcd_pkg.sv -----
// package for the sd clock divider select block
// shared constants, status codes, divider handshake structs and the prescaler table builder
// no dependencies
`timescale 1ns / 1ps

package sdcd_pkg;

	// fixed field widths
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned PFIELD_W  = 8;
	localparam int unsigned DFIELD_W  = 4;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// clock plan constants
	localparam int unsigned PRESCALER_LIMIT_DEF = 256;
	localparam int unsigned TOTAL_SPLIT         = 16;
	localparam int unsigned DIVISOR_MAX         = 16;
	localparam logic [DATA_W-1:0] SOURCE_RESET  = 32'd198000000;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DDR    = 1'b1;

	// prescaler candidate table: divisors of the limit, ascending, padded with the limit
	// entry width covers twice the largest supported limit
	localparam int unsigned PRE_TAB_W = 12;
	localparam int unsigned DIV_TAB_N = 64;

	typedef logic [DIV_TAB_N-1:0][PRE_TAB_W-1:0] pre_tab_t;

	// shared divider request and response
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
	} div_rsp_t;

	// builds the sorted list of divisors of n that are at least 2, by walking multiples
	function automatic pre_tab_t divisor_table(input int unsigned n);
		pre_tab_t    tab;
		int unsigned cnt;
		int unsigned m;
		for (int unsigned i = 0; i < DIV_TAB_N; i++) begin
			tab[i] = PRE_TAB_W'(n);
		end
		cnt = 0;
		for (int unsigned d = 2; d <= n; d++) begin
			m = d;
			while (m < n) begin
				m = m + d;
			end
			if ((m == n) && (cnt < DIV_TAB_N)) begin
				tab[cnt] = PRE_TAB_W'(d);
				cnt = cnt + 1;
			end
		end
		return tab;
	endfunction

endpackage

// ----- rtl/sd_clock_divider_select_top.sv -----
// top level of the sd clock divider select block
// sequencer around one shared divider and a prescaler candidate scan
// depends on sdcd_pkg and sdcd_div
//
//   port group      direction  handshake                     word
//   cfg_*           in         cfg_we, taken at the edge     source clock / ddr mode
//   target_clock_hz in         start while busy is low       wanted card clock
//   result fields   out        done, one cycle, no stall     fields, clock, status
//
// a zero target gives its word in the cycle after start
// otherwise the work runs on the shared divider, up to four divisions in a row,
// and the prescaler scan checks one candidate divisor of the limit per cycle:
// one division when the source is below the target, three for a small total divide, four
// plus the scan when it is split (the scan runs to the table end when the prescaler saturates)
// busy stays high until the word is on the outputs; reset leaves both registers at defaults
// the receiver cannot stall: each word is shown for exactly one cycle on done
`timescale 1ns / 1ps

module sd_clock_divider_select_top #(
	parameter int unsigned PRESCALER_LIMIT = sdcd_pkg::PRESCALER_LIMIT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sdcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdcd_pkg::DATA_W-1:0]      cfg_wdata,
	input  logic                             start,
	input  logic [sdcd_pkg::DATA_W-1:0]      target_clock_hz,
	output logic                             busy,
	output logic                             done,
	output logic [sdcd_pkg::PFIELD_W-1:0]    prescaler_field,
	output logic [sdcd_pkg::DFIELD_W-1:0]    divisor_field,
	output logic [sdcd_pkg::DATA_W-1:0]      achieved_clock_hz,
	output logic [sdcd_pkg::STATUS_W-1:0]    status
);

	import sdcd_pkg::*;

	// widths that follow from the limit
	localparam int unsigned PRE_W    = $clog2(2 * PRESCALER_LIMIT + 1);
	localparam int unsigned DIVV_W   = $clog2(DIVISOR_MAX + 1);
	localparam int unsigned PROD_W   = PRE_W + DIVV_W;
	localparam int unsigned IDX_W    = $clog2(DIV_TAB_N);
	localparam int unsigned SPLIT_SH = $clog2(TOTAL_SPLIT);

	localparam pre_tab_t TAB_SDR = divisor_table(PRESCALER_LIMIT);
	localparam pre_tab_t TAB_DDR = divisor_table(2 * PRESCALER_LIMIT);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TOTAL = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_CEIL  = 3'd4;
	localparam logic [2:0] S_PROD  = 3'd5;
	localparam logic [2:0] S_FREQ  = 3'd6;

	logic [2:0]          state_q;
	logic                done_q;
	logic                div_start_q;

	logic [DATA_W-1:0]   src_q;
	logic                ddr_q;

	logic [DATA_W-1:0]   tgt_q;
	logic [DATA_W-1:0]   total_q;
	logic [PRE_W-1:0]    pre_q;
	logic [DIVV_W-1:0]   divv_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0]    scan_idx_q;
	logic [DATA_W-1:0]   div_a_q;
	logic [DATA_W-1:0]   div_b_q;

	logic [PFIELD_W-1:0] pfield_q;
	logic [DFIELD_W-1:0] dfield_q;
	logic [DATA_W-1:0]   freq_q;
	logic [STATUS_W-1:0] stat_q;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                accept;
	logic [DATA_W-1:0]   total_adj;
	logic                total_pow2;
	logic [DATA_W-1:0]   want;
	logic [PRE_W-1:0]    scan_entry;
	logic                scan_hit;
	logic [DATA_W-1:0]   ceil_d;
	logic                ceil_sat;
	logic [PROD_W-1:0]   prod;
	logic [PRE_W+PFIELD_W-1:0] pre_shifted;

	// shared divider
	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_a_q;
	assign div_req.divisor  = div_b_q;

	sdcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// datapath decode for the current step
	always_comb begin
		total_adj   = total_q + DATA_W'(div_rsp.quotient > tgt_q);
		total_pow2  = ((total_adj & (total_adj - 1'b1)) == '0);
		want        = total_q >> SPLIT_SH;
		scan_entry  = ddr_q ? PRE_W'(TAB_DDR[scan_idx_q]) : PRE_W'(TAB_SDR[scan_idx_q]);
		scan_hit    = (DATA_W'(scan_entry) >= want) || (scan_idx_q == IDX_W'(DIV_TAB_N - 1));
		ceil_d      = div_rsp.quotient + DATA_W'(div_rsp.remainder != '0);
		ceil_sat    = ceil_d > DATA_W'(DIVISOR_MAX);
		prod        = PROD_W'(divv_q) * PROD_W'(pre_q);
		pre_shifted = {{PFIELD_W{1'b0}}, pre_q} >> (ddr_q ? 2 : 1);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SOURCE_RESET;
			ddr_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE: src_q <= cfg_wdata;
				CFG_DDR:    ddr_q <= cfg_wdata[0];
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (target_clock_hz == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q     <= S_TOTAL;
							div_start_q <= 1'b1;
						end
					end
				end
				S_TOTAL: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient == '0) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q     <= S_CHECK;
							div_start_q <= 1'b1;
						end
					end
				end
				S_CHECK: begin
					if (div_rsp.done) begin
						if (total_adj > DATA_W'(TOTAL_SPLIT)) begin
							state_q <= S_SCAN;
						end else begin
							state_q     <= S_FREQ;
							div_start_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q     <= S_CEIL;
						div_start_q <= 1'b1;
					end
				end
				S_CEIL: begin
					if (div_rsp.done) begin
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					state_q     <= S_FREQ;
					div_start_q <= 1'b1;
				end
				S_FREQ: begin
					if (div_rsp.done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers and result word
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					tgt_q   <= target_clock_hz;
					div_a_q <= src_q;
					div_b_q <= target_clock_hz;
					if (target_clock_hz == '0) begin
						pfield_q <= '0;
						dfield_q <= '0;
						freq_q   <= '0;
						stat_q   <= ST_ZERO;
					end
				end
			end
			S_TOTAL: begin
				if (div_rsp.done) begin
					total_q <= div_rsp.quotient;
					div_a_q <= src_q;
					div_b_q <= div_rsp.quotient;
					// source below target: pass the source clock straight through
					if (div_rsp.quotient == '0) begin
						pfield_q <= '0;
						dfield_q <= '0;
						freq_q   <= src_q;
						stat_q   <= ST_OK;
					end
				end
			end
			S_CHECK: begin
				if (div_rsp.done) begin
					total_q      <= total_adj;
					res_status_q <= ST_OK;
					scan_idx_q   <= '0;
					div_a_q      <= src_q;
					div_b_q      <= total_adj;
					// small total: prescaler alone for powers of two, divisor alone otherwise
					if (total_pow2) begin
						pre_q  <= PRE_W'(total_adj);
						divv_q <= '0;
					end else begin
						pre_q  <= '0;
						divv_q <= total_adj[DIVV_W-1:0];
					end
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					pre_q   <= scan_entry;
					div_a_q <= total_q;
					div_b_q <= DATA_W'(scan_entry);
				end else begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			S_CEIL: begin
				if (div_rsp.done) begin
					if (ceil_sat) begin
						divv_q       <= DIVV_W'(DIVISOR_MAX);
						res_status_q <= ST_SAT;
					end else begin
						divv_q <= ceil_d[DIVV_W-1:0];
					end
				end
			end
			S_PROD: begin
				div_a_q <= src_q;
				div_b_q <= DATA_W'(prod);
			end
			S_FREQ: begin
				if (div_rsp.done) begin
					freq_q   <= div_rsp.quotient;
					pfield_q <= pre_shifted[PFIELD_W-1:0];
					dfield_q <= (divv_q != '0) ? DFIELD_W'(divv_q - 1'b1) : '0;
					stat_q   <= res_status_q;
				end
			end
			default: begin
				scan_idx_q <= '0;
			end
		endcase
	end

	assign done              = done_q;
	assign prescaler_field   = pfield_q;
	assign divisor_field     = dfield_q;
	assign achieved_clock_hz = freq_q;
	assign status            = stat_q;

	// a word is only given once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while sequencer still busy");

	// an accepted request either starts work or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted request neither started nor answered");

	// a zero target clears every field
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_ZERO)) |->
			((prescaler_field == '0) && (divisor_field == '0) && (achieved_clock_hz == '0)))
		else $error("zero target word carries nonzero fields");

	// a saturated divisor always encodes the largest field value
	a_sat_field: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_SAT)) |-> (divisor_field == DFIELD_W'(DIVISOR_MAX - 1)))
		else $error("saturated status without saturated divisor field");

endmodule

// ----- rtl/sdcd_div.sv -----
// shared radix-2 restoring divider for the sd clock divider select block
// one quotient bit per cycle, registered quotient and remainder
// depends on sdcd_pkg
`timescale 1ns / 1ps

module sdcd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sdcd_pkg::div_req_t req,
	output sdcd_pkg::div_rsp_t rsp
);

	import sdcd_pkg::*;

	localparam int unsigned CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dsr_q;

	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              fits;

	// one restoring step: shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {rem_q, quo_q[DATA_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W - 1);
			end
		end
	end

	// datapath: quotient shifts in from the bottom as the dividend shifts out the top
	always_ff @(posedge clk) begin
		if (busy_q) begin
			quo_q <= {quo_q[DATA_W-2:0], fits};
			rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		end else if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
